@@ sv/url_percent_decoder_unit_defines.svh @@
// ----------------------------------------------------------------------------
// url_percent_decoder_unit_defines
// Assertion macros shared by the checker of the URL percent decoder.
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODER_UNIT_DEFINES_SVH
`define URL_PERCENT_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define UPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define UPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/upd_pkg.sv @@
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character constants and classification helpers of the URL decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_TILDE    = 8'h7E;

  // Offsets that map an ASCII hex digit onto its value
  localparam logic [7:0] OFS_DIGIT = 8'h30;
  localparam logic [7:0] OFS_UPPER = 8'h37;
  localparam logic [7:0] OFS_LOWER = 8'h57;

  typedef enum logic [1:0] {
    CLS_ALLOWED = 2'd0,
    CLS_PERCENT = 2'd1,
    CLS_TERM    = 2'd2,
    CLS_ILLEGAL = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ILLEGAL   = 2'd1,
    ST_BAD_DIGIT = 2'd2,
    ST_CUT_SHORT = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] raw;
    logic       last;
    cls_t       cls;
    logic       hex_ok;
    logic [3:0] hex_val;
  } item_t;

  function automatic logic is_hex(input logic [7:0] b);
    logic r;
    case (b) inside
      ["0":"9"], ["A":"F"], ["a":"f"]: r = 1'b1;
      default:                         r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    case (b) inside
      ["A":"F"]: d = b - OFS_UPPER;
      ["a":"f"]: d = b - OFS_LOWER;
      default:   d = b - OFS_DIGIT;
    endcase
    return d[3:0];
  endfunction

  function automatic logic allowed_char(input logic [7:0] b, input logic braces);
    logic r;
    case (b) inside
      ["a":"z"], ["A":"Z"], ["0":"9"],
      "-", "_", ".", CH_TILDE, "!", "*", "'", "(", ")", ";", ":", "@",
      "=", "+", "$", ",", "/", "[", "]", "&":
        r = 1'b1;
      CH_LBRACE, CH_RBRACE:
        r = braces;
      default:
        r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/upd_front.sv @@
// ----------------------------------------------------------------------------
// upd_front
// Accepts raw bytes, classifies them and pushes them into the work queue.
// Also holds the brace-enable configuration register.
// ----------------------------------------------------------------------------
module upd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data,
  input  logic           q_full,
  output logic           q_push,
  output upd_pkg::item_t q_item
);

  logic allow_braces_r;
  logic allow_braces_nxt;

  assign cfg_ready = 1'b1;
  assign allow_braces_nxt = (cfg_valid && cfg_ready) ? cfg_data : allow_braces_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_braces_r <= 1'b1;
    end else begin
      allow_braces_r <= allow_braces_nxt;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.raw     = in_byte;
    q_item.last    = in_last;
    q_item.hex_ok  = upd_pkg::is_hex(in_byte);
    q_item.hex_val = upd_pkg::hex_value(in_byte);
    if (in_byte == upd_pkg::CH_QUESTION || in_byte == upd_pkg::CH_HASH ||
        in_byte == upd_pkg::CH_NUL) begin
      q_item.cls = upd_pkg::CLS_TERM;
    end else if (in_byte == upd_pkg::CH_PERCENT) begin
      q_item.cls = upd_pkg::CLS_PERCENT;
    end else if (upd_pkg::allowed_char(in_byte, allow_braces_r)) begin
      q_item.cls = upd_pkg::CLS_ALLOWED;
    end else begin
      q_item.cls = upd_pkg::CLS_ILLEGAL;
    end
  end

endmodule

@@ sv/upd_fifo.sv @@
// ----------------------------------------------------------------------------
// upd_fifo
// Short register queue of classified words between front and back.
// ----------------------------------------------------------------------------
module upd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  upd_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output upd_pkg::item_t head_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  upd_pkg::item_t slots_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ sv/upd_back.sv @@
// ----------------------------------------------------------------------------
// upd_back
// Escape state machine: consumes classified words and fills the output register.
// ----------------------------------------------------------------------------
module upd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  upd_pkg::item_t    head_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_has_byte,
  output logic              out_url_end,
  output upd_pkg::status_t  out_status
);

  typedef enum logic [3:0] {
    PH_PLAIN = 4'b0001,
    PH_HI    = 4'b0010,
    PH_LO    = 4'b0100,
    PH_SKIP  = 4'b1000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [3:0]        nib_r, nib_nxt;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_has_byte_r;
  logic              out_url_end_r;
  upd_pkg::status_t  out_status_r;

  logic              emit, fin, slot_free, take;
  logic [7:0]        ob;
  logic              hb;
  upd_pkg::status_t  st;

  always_comb begin
    phase_nxt = phase_r;
    nib_nxt   = nib_r;
    emit      = 1'b0;
    fin       = 1'b0;
    ob        = '0;
    hb        = 1'b0;
    st        = upd_pkg::ST_OK;
    if (phase_r == PH_SKIP) begin
      // drop until the last-byte mark
      if (head_item.last) begin
        phase_nxt = PH_PLAIN;
      end
    end else if (head_item.cls == upd_pkg::CLS_TERM) begin
      fin = 1'b1;
      st  = (phase_r == PH_PLAIN) ? upd_pkg::ST_OK : upd_pkg::ST_CUT_SHORT;
    end else begin
      case (phase_r)
        PH_PLAIN: begin
          if (head_item.cls == upd_pkg::CLS_PERCENT) begin
            phase_nxt = PH_HI;
            if (head_item.last) begin
              fin = 1'b1;
              st  = upd_pkg::ST_CUT_SHORT;
            end
          end else if (head_item.cls == upd_pkg::CLS_ALLOWED) begin
            ob   = head_item.raw;
            hb   = 1'b1;
            emit = 1'b1;
            fin  = head_item.last;
          end else begin
            fin = 1'b1;
            st  = upd_pkg::ST_ILLEGAL;
          end
        end
        PH_HI: begin
          if (head_item.hex_ok) begin
            nib_nxt   = head_item.hex_val;
            phase_nxt = PH_LO;
            if (head_item.last) begin
              fin = 1'b1;
              st  = upd_pkg::ST_CUT_SHORT;
            end
          end else begin
            fin = 1'b1;
            st  = upd_pkg::ST_BAD_DIGIT;
          end
        end
        PH_LO: begin
          if (head_item.hex_ok) begin
            ob        = {nib_r, head_item.hex_val};
            hb        = 1'b1;
            emit      = 1'b1;
            phase_nxt = PH_PLAIN;
            nib_nxt   = '0;
            fin       = head_item.last;
          end else begin
            fin = 1'b1;
            st  = upd_pkg::ST_BAD_DIGIT;
          end
        end
        default: begin
          phase_nxt = PH_PLAIN;
        end
      endcase
    end
    if (fin) begin
      emit      = 1'b1;
      phase_nxt = head_item.last ? PH_PLAIN : PH_SKIP;
      nib_nxt   = '0;
    end
  end

  // A word with no result never waits on the output side
  assign slot_free = !out_valid_r || !out_stall;
  assign take      = head_valid && (!emit || slot_free);
  assign pop       = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PLAIN;
      nib_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        nib_r   <= nib_nxt;
      end
      if (take && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_byte_r     <= ob;
      out_has_byte_r <= hb;
      out_url_end_r  <= fin;
      out_status_r   <= st;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_has_byte = out_has_byte_r;
  assign out_url_end  = out_url_end_r;
  assign out_status   = out_status_r;

endmodule

@@ sv/url_percent_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// Percent-decoder for URL path bytes with end-of-URL and error reporting.
// ----------------------------------------------------------------------------
// Takes one raw URL byte per cycle while in_stall is low and returns at most
// one result per byte: a passed or decoded byte, or a final word with url_end
// and a status. The sustained rate is one byte per clock, set by the escape
// state machine in the back end, which retires one queued byte per cycle
// unless its result waits on out_stall. An accepted byte is written into a
// queue slot, and the back end loads its result from the queue head into the
// output register when nothing stalls. Up to FIFO_DEPTH classified bytes
// wait between front and back, and a held result does not stop acceptance
// until that queue fills. The brace-enable bit resets to 1 and may be written
// only while the block is idle; cfg_ready is always high.
module url_percent_decoder_unit #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_url_end,
  output logic [1:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic              q_full, q_push, q_pop, q_head_valid;
  upd_pkg::item_t    q_push_item, q_head_item;
  upd_pkg::status_t  status;

  upd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  upd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  upd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (q_head_valid),
    .head_item    (q_head_item),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_url_end  (out_url_end),
    .out_status   (status)
  );

  assign out_status = status;

endmodule

@@ sv/upd_checker.sv @@
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks of the URL percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "url_percent_decoder_unit_defines.svh"

module upd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_has_byte,
  input logic       out_url_end,
  input logic [1:0] out_status
);

  // An error status only rides on the closing word
  `UPD_ASSERT_IMP(a_status_on_end, out_valid && (out_status != upd_pkg::ST_OK), out_url_end, "nonzero status without url_end")

  // A word without a byte always closes the URL
  `UPD_ASSERT_IMP(a_empty_is_end, out_valid && !out_has_byte, out_url_end, "empty result not marked as end")

  // A word without a byte carries a zero byte field
  `UPD_ASSERT_IMP(a_empty_byte_zero, out_valid && !out_has_byte, out_byte == 8'h00, "byte field set without has_byte")

  // Hold a stalled result
  `UPD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_status), "stalled result changed")

endmodule

bind url_percent_decoder_unit upd_checker u_upd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .out_has_byte (out_has_byte),
  .out_url_end  (out_url_end),
  .out_status   (out_status)
);
